@@ rtl/ftxr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftxr_pkg
// Shared constants and types for the four-tap XOR random generator.
// ----------------------------------------------------------------------------
package ftxr_pkg;
    localparam int TABLE_DEPTH_DEF = 16384;
    localparam int WORD_W = 31;
    localparam int LAG_A = 471;
    localparam int LAG_B = 1586;
    localparam int LAG_C = 6988;
    localparam int LAG_D = 9689;
    localparam logic [14:0] PM_MULT = 15'd16807;
    localparam logic [30:0] PM_MOD = 31'h7FFF_FFFF;
    localparam logic [1:0] REQ_RESEED = 2'd0;
    localparam logic [1:0] REQ_INT = 2'd1;
    localparam logic [1:0] REQ_FRAC = 2'd2;
    localparam logic ST_OK = 1'b0;
    localparam logic ST_ZERO_BOUND = 1'b1;
    localparam logic [1:0] CFG_SEED = 2'd0;
    typedef struct packed {
        logic start;
        logic [30:0] dividend;
        logic [30:0] divisor;
    } t_div_req;
    typedef struct packed {
        logic busy;
        logic done;
        logic [30:0] rem;
    } t_div_rsp;
endpackage

@@ rtl/ftxr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftxr_req_if / ftxr_rsp_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface ftxr_req_if;
    logic valid;
    logic ready;
    logic [1:0] req_type;
    logic [30:0] bound;
    modport source (output valid, output req_type, output bound, input ready);
    modport sink (input valid, input req_type, input bound, output ready);
endinterface

interface ftxr_rsp_if;
    logic valid;
    logic ready;
    logic [30:0] value;
    logic status;
    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

@@ rtl/ftxr_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftxr_divider
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ftxr_divider
    import ftxr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [30:0] r_rem, n_rem;
    logic [30:0] r_quo, n_quo;
    logic [30:0] r_div, n_div;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [31:0] w_trial;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_div = r_div;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[30]};
        if (i_req.start) begin
            n_rem = '0;
            n_quo = i_req.dividend;
            n_div = i_req.divisor;
            n_cnt = 5'd30;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[29:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = 31'(w_trial - {1'b0, r_div});
            end else begin
                n_rem = w_trial[30:0];
            end
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_rsp = '{busy: r_busy, done: r_done, rem: r_rem};

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div)) else $error("remainder not reduced");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("start while busy");
`endif
endmodule

@@ rtl/four_tap_xor_random_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_tap_xor_random_generator_unit
// Four-tap XOR lagged-Fibonacci generator over a table of 31-bit words.
// ----------------------------------------------------------------------------
// A fraction draw reads the table's read port at four lags in turn, XORs the
// words and then writes the result back. An integer draw with a nonzero bound
// also runs the bit-serial remainder unit. For each table entry a reseed
// registers the Park-Miller product in S_MUL, then folds it and writes the
// entry in S_FOLD. The unit takes one word at a time; results are held in an
// output register until taken. The table holds no defined contents before the
// first reseed, and draws before it return zero.
module four_tap_xor_random_generator_unit
    import ftxr_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ftxr_req_if.sink    i_req,
    ftxr_rsp_if.source  o_rsp
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_WR = 3'd2, S_DIV = 3'd3,
                           S_OUT = 3'd4, S_MUL = 3'd5, S_FOLD = 3'd6;

    logic [30:0] r_seed;
    logic [2:0]  r_state;
    logic [IW-1:0] r_idx, r_addr, r_fill;
    logic [2:0]  r_tap;
    logic        r_seeded;
    logic [30:0] r_acc, r_prev, r_bound;
    logic [1:0]  r_req;
    logic [45:0] r_prod;
    logic        r_ovalid;
    logic [30:0] r_oval;
    logic        r_ostat;
    logic [30:0] r_mem [TABLE_DEPTH];
    logic [30:0] r_rdata;
    logic        w_we;
    logic [IW-1:0] w_waddr, w_raddr, w_lag;
    logic [30:0] w_wdata, w_fold;
    logic [31:0] w_sum;
    t_div_req    w_dreq;
    t_div_rsp    w_drsp;

    assign pready = 1'b1;
    assign prdata = (paddr == CFG_SEED) ? {1'b0, r_seed} : 32'd0;

    always_comb begin
        case (r_tap)
            3'd0: w_lag = IW'(LAG_A);
            3'd1: w_lag = IW'(LAG_B);
            3'd2: w_lag = IW'(LAG_C);
            default: w_lag = IW'(LAG_D);
        endcase
    end
    assign w_raddr = r_addr - w_lag;
    assign w_sum = {17'd0, r_prod[45:31]} + {1'b0, r_prod[30:0]};
    assign w_fold = (w_sum >= {1'b0, PM_MOD}) ? 31'(w_sum - {1'b0, PM_MOD})
                                              : w_sum[30:0];

    assign w_we = (r_state == S_WR) || (r_state == S_FOLD);
    assign w_waddr = (r_state == S_WR) ? r_addr : r_fill;
    assign w_wdata = (r_state == S_WR) ? (r_seeded ? r_acc : 31'd0) : w_fold;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    assign w_dreq.start = (r_state == S_WR) && (r_req == REQ_INT) && (r_bound != 31'd0);
    assign w_dreq.dividend = r_seeded ? r_acc : 31'd0;
    assign w_dreq.divisor = r_bound;

    ftxr_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.value = r_oval;
    assign o_rsp.status = r_ostat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_state <= S_IDLE;
            r_idx <= '0;
            r_seeded <= 1'b0;
            r_ovalid <= 1'b0;
            r_tap <= '0;
        end else begin
            if (psel && penable && pwrite && paddr == CFG_SEED) r_seed <= pwdata[30:0];
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req <= i_req.req_type;
                        r_bound <= i_req.bound;
                        r_oval <= '0;
                        r_ostat <= ST_OK;
                        if (i_req.req_type == REQ_RESEED) begin
                            r_prev <= r_seed;
                            r_fill <= '0;
                            r_state <= S_MUL;
                        end else if (i_req.req_type == REQ_INT ||
                                     i_req.req_type == REQ_FRAC) begin
                            r_addr <= r_idx + IW'(1);
                            r_idx <= r_idx + IW'(1);
                            r_tap <= '0;
                            r_acc <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_ovalid <= 1'b1;
                        end
                    end
                end
                S_RD: begin
                    if (r_tap != 3'd4) r_tap <= r_tap + 3'd1;
                    if (r_tap != 3'd0) r_acc <= r_acc ^ r_rdata;
                    if (r_tap == 3'd4) r_state <= S_WR;
                end
                S_WR: begin
                    if (r_req == REQ_INT && r_bound != 31'd0) begin
                        r_state <= S_DIV;
                    end else begin
                        r_oval <= (r_req == REQ_FRAC && r_seeded) ? r_acc : 31'd0;
                        r_ostat <= (r_req == REQ_INT) ? ST_ZERO_BOUND : ST_OK;
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_oval <= w_drsp.rem;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_MUL: begin
                    r_prod <= 46'(r_prev) * 46'(PM_MULT);
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_prev <= w_fold;
                    r_fill <= r_fill + IW'(1);
                    if (r_fill == IW'(TABLE_DEPTH - 1)) begin
                        r_seeded <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_state == S_IDLE)) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_rsp.ready) |=> (r_ovalid && $stable(r_oval)))
        else $error("result dropped");
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drsp.done |-> (r_state == S_DIV)) else $error("stray remainder");
    a_seed_on_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_seeded) |-> ($past(r_state) == S_FOLD)) else $error("bad seed flag");
`endif
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-tap XOR lagged-Fibonacci generator.
// Seeds are written over the APB port while the unit is idle. Each phase
// reseeds the table and then issues draws. Every accepted request is run
// through a local copy of the generator table, and the expected word is
// queued. Returned words are compared in order, with random gaps on either
// side of the exchange outside the calm phases.
// ----------------------------------------------------------------------------
module testbench;
    import ftxr_pkg::*;

    localparam int DEPTH = 16384;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [30:0] value;
        logic        status;
    } t_word;

    typedef struct {
        logic [1:0]  req;
        logic [30:0] bound;
        bit          typed;
        logic [30:0] value;
        logic        status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ftxr_req_if req_ch ();
    ftxr_rsp_if rsp_ch ();

    bit [30:0]   lag_words [DEPTH];
    bit [13:0]   run_index;
    bit          seeded;
    bit [30:0]   seed_reg;
    t_word       pending_words [$];
    int          errors;
    int          quiet_cycles;
    int          rsp_hold;
    bit          rsp_calm;
    bit          req_calm;
    t_row        rows [$];

    four_tap_xor_random_generator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_RESEED;
        req_ch.bound = '0;
        rsp_ch.ready = 1'b0;
        rsp_hold = 0;
    end

    function automatic bit [30:0] park_miller(bit [30:0] x);
        longint unsigned p;
        p = 64'(16807) * 64'(x);
        return 31'(p % 64'(2147483647));
    endfunction

    function automatic t_word predict_word(logic [1:0] req, logic [30:0] bound);
        t_word     r;
        bit [13:0] n;
        bit [30:0] w;
        r = '0;
        if (req == REQ_RESEED) begin
            lag_words[0] = park_miller(seed_reg);
            for (int i = 1; i < DEPTH; i++) lag_words[i] = park_miller(lag_words[i-1]);
            seeded = 1'b1;
        end else if (req == REQ_INT || req == REQ_FRAC) begin
            n = run_index + 14'd1;
            run_index = n;
            w = lag_words[14'(n - LAG_A)] ^ lag_words[14'(n - LAG_B)]
              ^ lag_words[14'(n - LAG_C)] ^ lag_words[14'(n - LAG_D)];
            if (!seeded) w = '0;
            lag_words[n] = w;
            if (req == REQ_FRAC) begin
                r.value = w;
            end else if (bound == '0) begin
                r.status = ST_ZERO_BOUND;
            end else begin
                r.value = w % bound;
            end
        end
        return r;
    endfunction

    task automatic send_request(logic [1:0] req, logic [30:0] bound,
                                bit typed, t_word typed_word);
        int    gap;
        int    roll;
        t_word w;
        roll = $urandom_range(0, 99);
        if (req_calm || roll < 60) gap = 0;
        else if (roll < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(5, 40);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= req;
        req_ch.bound <= bound;
        do @(posedge i_clk); while (!req_ch.ready);
        w = predict_word(req, bound);
        if (typed && w != typed_word) begin
            $display("%0t: table row disagrees with predictor: %h vs %h",
                     $time, typed_word, w);
            errors++;
        end
        pending_words.push_back(w);
    endtask

    task automatic wait_idle();
        if (req_ch.valid) req_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_seed(logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'(4 * CFG_SEED);
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        seed_reg = data[30:0];
        @(posedge i_clk);
    endtask

    function automatic logic [30:0] random_bound();
        int k;
        k = $urandom_range(0, 99);
        if (k < 3) return '0;
        if (k < 30) return 31'($urandom_range(1, 16));
        if (k < 45) return 31'(1) << $urandom_range(0, 30);
        if (k < 50) return 31'h7FFF_FFFF;
        return 31'($urandom());
    endfunction

    task automatic random_phase(int count);
        int          k;
        logic [1:0]  req;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 999);
            if (k < 470) req = REQ_INT;
            else if (k < 940) req = REQ_FRAC;
            else if (k < 998) req = REQ_UNUSED;
            else req = REQ_RESEED;
            send_request(req, random_bound(), 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            got.value = rsp_ch.value;
            got.status = rsp_ch.status;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word value=%h status=%b",
                         $time, got.value, got.status);
                errors++;
            end else begin
                want = pending_words.pop_front();
                if (got.value !== want.value) begin
                    $display("%0t: value expected %h actual %h",
                             $time, want.value, got.value);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %b actual %b",
                             $time, want.status, got.status);
                    errors++;
                end
            end
        end
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_calm) begin
            rsp_ch.ready <= 1'b1;
        end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 3) begin
            rsp_hold = $urandom_range(5, 40);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL four_tap_xor_random_generator_unit");
            $finish;
        end
    end

    initial begin
        logic [31:0] seeds [6];
        t_word       tw;
        errors = 0;
        run_index = '0;
        seeded = 1'b0;
        seed_reg = '0;
        rsp_calm = 1'b0;
        req_calm = 1'b0;
        for (int i = 0; i < DEPTH; i++) lag_words[i] = '0;

        rows.push_back('{REQ_RESEED, 31'h7FFF_FFFF, 1, '0, ST_OK});
        rows.push_back('{REQ_UNUSED, 31'h7FFF_FFFF, 1, '0, ST_OK});
        rows.push_back('{REQ_INT, '0, 0, '0, ST_OK});
        rows.push_back('{REQ_INT, 31'd1, 1, '0, ST_OK});
        rows.push_back('{REQ_INT, 31'h7FFF_FFFF, 0, '0, ST_OK});
        rows.push_back('{REQ_FRAC, '0, 0, '0, ST_OK});
        rows.push_back('{REQ_FRAC, 31'h7FFF_FFFF, 0, '0, ST_OK});
        rows.push_back('{REQ_INT, 31'd2, 0, '0, ST_OK});
        rows.push_back('{REQ_INT, 31'h4000_0000, 0, '0, ST_OK});
        rows.push_back('{REQ_INT, 31'h5555_5555, 0, '0, ST_OK});
        rows.push_back('{REQ_INT, 31'h2AAA_AAAA, 0, '0, ST_OK});
        rows.push_back('{REQ_UNUSED, '0, 1, '0, ST_OK});
        rows.push_back('{REQ_INT, '0, 0, '0, ST_OK});
        rows.push_back('{REQ_FRAC, 31'h1234_5678, 0, '0, ST_OK});
        rows.push_back('{REQ_INT, 31'd3, 0, '0, ST_OK});
        rows.push_back('{REQ_INT, 31'h7FFF_FFFE, 0, '0, ST_OK});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_seed(32'd1);
        foreach (rows[i]) begin
            tw.value = rows[i].value;
            tw.status = rows[i].status;
            if (rows[i].req == REQ_INT && rows[i].bound == '0) begin
                tw.value = '0;
                tw.status = ST_ZERO_BOUND;
                send_request(rows[i].req, rows[i].bound, 1'b1, tw);
            end else begin
                send_request(rows[i].req, rows[i].bound, rows[i].typed, tw);
            end
        end
        random_phase(440);
        wait_idle();

        seeds[0] = 32'd0;
        seeds[1] = 32'h7FFF_FFFF;
        seeds[2] = 32'h7FFF_FFFE;
        seeds[3] = $urandom();
        seeds[4] = $urandom();
        seeds[5] = {1'b0, 31'($urandom())};
        for (int p = 0; p < 6; p++) begin
            rsp_calm = (p == 2);
            req_calm = (p == 3);
            write_seed(seeds[p]);
            tw = '0;
            send_request(REQ_RESEED, 31'($urandom()), 1'b1, tw);
            random_phase((p < 2) ? 80 : 320);
            wait_idle();
        end

        if (errors == 0) begin
            $display("PASS four_tap_xor_random_generator_unit");
        end else begin
            $display("FAIL four_tap_xor_random_generator_unit");
        end
        $finish;
    end
endmodule
